// ===== hw/rtl/sm3_pkg.sv =====
package sm3_pkg;

    // SM3 initial chaining value
    localparam logic [31:0] IV [8] = '{
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    // round constant for rounds 0..15, and that of rounds 16..63 pre-rotated by 16
    localparam logic [31:0] T_LOW      = 32'h79CC4519;
    localparam logic [31:0] T_HIGH_R16 = 32'h9D8A7A87;
    localparam logic [31:0] PAD_WORD   = 32'h80000000;
    localparam logic [3:0]  LEN_SLOT   = 4'd14;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

    // one queued word, already classified by the front end
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } sm3_item_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // short final word: keep the valid bytes, place the pad byte after them
    function automatic logic [31:0] pad_short(input logic [31:0] w, input logic [2:0] c);
        logic [31:0] r;
        case (c)
            3'd0:    r = 32'h80000000;
            3'd1:    r = {w[31:24], 24'h800000};
            3'd2:    r = {w[31:16], 16'h8000};
            3'd3:    r = {w[31:8], 8'h80};
            default: r = w;
        endcase
        pad_short = r;
    endfunction

endpackage

// ===== hw/rtl/sm3_hash_engine_core.sv =====
// SM3 digest engine. An ordinary word passes through the queue into the engine;
// every 16th word starts a 64-round compression, one round per cycle, during which
// the engine takes no further words from the queue.
// A final word adds padding words, one or two compressions, then eight
// digest transfers. Reset (aresetn, synchronous, active low) empties the queue and
// loads the SM3 initial value.
module sm3_hash_engine_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_digest_done
);

    logic               q_valid;
    logic               q_pop;
    sm3_pkg::sm3_item_t q_item;

    // input side: classify and queue
    sm3_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_last_word    (s_last_word),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop)
    );

    // padding, compression and digest output
    sm3_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_digest_done (m_digest_done)
    );

endmodule

// ===== hw/rtl/sm3_front.sv =====
module sm3_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_message_word,
    input  logic [2:0]            s_byte_count,
    input  logic                  s_last_word,
    output logic                  q_valid,
    output sm3_pkg::sm3_item_t    q_item,
    input  logic                  q_pop
);

    sm3_pkg::sm3_item_t fifo_reg [4];
    logic [1:0] wptr_reg, wptr_next;
    logic [1:0] rptr_reg, rptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       push, pop;
    sm3_pkg::sm3_item_t in_item;

    // classify: only a final word may carry fewer than four bytes
    always_comb begin
        in_item.word = s_message_word;
        in_item.last = s_last_word;
        if (!s_last_word || s_byte_count > sm3_pkg::FULL_BYTES) begin
            in_item.cnt = sm3_pkg::FULL_BYTES;
        end else begin
            in_item.cnt = s_byte_count;
        end
    end

    assign s_ready = (cnt_reg != 3'd4);
    assign q_valid = (cnt_reg != 3'd0);
    assign q_item  = fifo_reg[rptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wptr_next = push ? wptr_reg + 2'd1 : wptr_reg;
        rptr_next = pop ? rptr_reg + 2'd1 : rptr_reg;
        cnt_next  = cnt_reg + {2'b0, push} - {2'b0, pop};
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wptr_reg] <= in_item;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 2'd0;
            rptr_reg <= 2'd0;
            cnt_reg  <= 3'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/sm3_back.sv =====
module sm3_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  sm3_pkg::sm3_item_t    q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_digest_word,
    output logic [2:0]            m_word_index,
    output logic                  m_digest_done
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_COMP = 4'b0010,
        ST_PAD  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    typedef enum logic [2:0] {
        PH_P80   = 3'b001,
        PH_ZERO  = 3'b010,
        PH_LENLO = 3'b100
    } phase_t;

    state_t      state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] v_reg [8];
    logic [31:0] v_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next, f_next, g_next, h_next;
    logic [31:0] t_reg, t_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  wib_reg, wib_next;
    logic [60:0] bytes_reg, bytes_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_reg, pad_next;
    logic        fin_reg, fin_next;

    logic        push_en;
    logic [31:0] push_word;
    logic        full;
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

    // one compression round
    always_comb begin
        a12 = sm3_pkg::rotl(a_reg, 5'd12);
        ss1 = sm3_pkg::rotl(a12 + e_reg + t_reg, 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16) begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end else begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + h_reg + ss1 + win_reg[0];
        w_new = sm3_pkg::perm1(win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15))
              ^ sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    assign full    = push_en && (wib_reg == 4'd15);
    assign q_pop   = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_digest_word = v_reg[idx_reg];
    assign m_word_index  = idx_reg;
    assign m_digest_done = (idx_reg == 3'd7);

    // sequencer
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        bytes_next = bytes_reg;
        idx_next   = idx_reg;
        pad_next   = pad_reg;
        fin_next   = fin_reg;
        push_en    = 1'b0;
        push_word  = '0;
        for (int i = 0; i < 8; i++) begin
            v_next[i] = v_reg[i];
        end
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    push_en = 1'b1;
                    if (!q_item.last) begin
                        push_word  = q_item.word;
                        bytes_next = bytes_reg + 61'd4;
                        state_next = full ? ST_COMP : ST_IDLE;
                    end else begin
                        bytes_next = bytes_reg + {58'd0, q_item.cnt};
                        pad_next   = 1'b1;
                        if (q_item.cnt == sm3_pkg::FULL_BYTES) begin
                            push_word  = q_item.word;
                            phase_next = PH_P80;
                        end else begin
                            push_word  = sm3_pkg::pad_short(q_item.word, q_item.cnt);
                            phase_next = PH_ZERO;
                        end
                        state_next = full ? ST_COMP : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
                case (phase_reg)
                    PH_P80: begin
                        push_word  = sm3_pkg::PAD_WORD;
                        phase_next = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (wib_reg != sm3_pkg::LEN_SLOT) begin
                            push_word = '0;
                        end else begin
                            push_word  = bytes_reg[60:29];
                            phase_next = PH_LENLO;
                        end
                    end
                    PH_LENLO: begin
                        push_word = {bytes_reg[28:0], 3'b000};
                        pad_next  = 1'b0;
                        fin_next  = 1'b1;
                    end
                    default: begin
                        push_word = '0;
                    end
                endcase
                state_next = full ? ST_COMP : ST_PAD;
            end
            ST_COMP: begin
                if (rnd_reg == 6'd63) begin
                    v_next[0] = v_reg[0] ^ tt1;
                    v_next[1] = v_reg[1] ^ a_reg;
                    v_next[2] = v_reg[2] ^ sm3_pkg::rotl(b_reg, 5'd9);
                    v_next[3] = v_reg[3] ^ c_reg;
                    v_next[4] = v_reg[4] ^ sm3_pkg::perm0(tt2);
                    v_next[5] = v_reg[5] ^ e_reg;
                    v_next[6] = v_reg[6] ^ sm3_pkg::rotl(f_reg, 5'd19);
                    v_next[7] = v_reg[7] ^ g_reg;
                    if (fin_reg) begin
                        state_next = ST_OUT;
                    end else if (pad_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        for (int i = 0; i < 8; i++) begin
                            v_next[i] = sm3_pkg::IV[i];
                        end
                        bytes_next = '0;
                        fin_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // block window, working variables and round constant
    always_comb begin
        wib_next = wib_reg;
        rnd_next = rnd_reg;
        for (int i = 0; i < 16; i++) begin
            win_next[i] = win_reg[i];
        end
        {a_next, b_next, c_next, d_next} = {a_reg, b_reg, c_reg, d_reg};
        {e_next, f_next, g_next, h_next} = {e_reg, f_reg, g_reg, h_reg};
        t_next = t_reg;
        if (push_en) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = push_word;
            wib_next = wib_reg + 4'd1;
        end
        if (full) begin
            {a_next, b_next, c_next, d_next} = {v_reg[0], v_reg[1], v_reg[2], v_reg[3]};
            {e_next, f_next, g_next, h_next} = {v_reg[4], v_reg[5], v_reg[6], v_reg[7]};
            t_next   = sm3_pkg::T_LOW;
            rnd_next = 6'd0;
        end
        if (state_reg == ST_COMP) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = w_new;
            a_next = tt1;
            b_next = a_reg;
            c_next = sm3_pkg::rotl(b_reg, 5'd9);
            d_next = c_reg;
            e_next = sm3_pkg::perm0(tt2);
            f_next = e_reg;
            g_next = sm3_pkg::rotl(f_reg, 5'd19);
            h_next = g_reg;
            t_next = (rnd_reg == 6'd15) ? sm3_pkg::T_HIGH_R16 : sm3_pkg::rotl(t_reg, 5'd1);
            rnd_next = rnd_reg + 6'd1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 16; i++) begin
            win_reg[i] <= win_next[i];
        end
        {a_reg, b_reg, c_reg, d_reg} <= {a_next, b_next, c_next, d_next};
        {e_reg, f_reg, g_reg, h_reg} <= {e_next, f_next, g_next, h_next};
        t_reg     <= t_next;
        rnd_reg   <= rnd_next;
        phase_reg <= phase_next;
    end

    // control state and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wib_reg   <= 4'd0;
            bytes_reg <= '0;
            idx_reg   <= 3'd0;
            pad_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= sm3_pkg::IV[i];
            end
        end else begin
            state_reg <= state_next;
            wib_reg   <= wib_next;
            bytes_reg <= bytes_next;
            idx_reg   <= idx_next;
            pad_reg   <= pad_next;
            fin_reg   <= fin_next;
            for (int i = 0; i < 8; i++) begin
                v_reg[i] <= v_next[i];
            end
        end
    end

endmodule

// ===== hw/rtl/sm3_checker.sv =====
module sm3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_digest_word,
    input logic [2:0]  m_word_index,
    input logic        m_digest_done
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // done flag marks the eighth word only
    a_done_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digest_done == (m_word_index == 3'd7)))
        else $error("done flag mismatch");

    // digest words follow back to back in index order
    a_idx_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_digest_done |=>
            m_valid && m_word_index == $past(m_word_index) + 3'd1)
        else $error("digest word order broken");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("stalled result changed");

endmodule

bind sm3_hash_engine_core sm3_checker u_sm3_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_digest_done (m_digest_done)
);
